[rtl/core/srte_pkg.sv]
// Package: constants, types and helper functions for the source route table engine.
package srte_pkg;

  localparam int unsigned SLOTS   = 16;
  localparam int unsigned HOPS    = 8;
  localparam int unsigned SLOT_W  = $clog2(SLOTS);
  localparam int unsigned HOP_W   = $clog2(HOPS);
  localparam int unsigned SCNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned HCNT_W  = $clog2(HOPS + 1);
  localparam int unsigned TPU_W   = 31;
  localparam int unsigned AGE_W   = TPU_W + 8;
  localparam logic [7:0]  LIFE_INF = 8'd255;
  localparam logic [TPU_W-1:0] TPU_RESET = TPU_W'(1);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_EXPIRE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXP1,
    S_EXP2,
    S_COPY,
    S_LRD,
    S_LOUT,
    S_POST
  } state_t;

  typedef struct packed {
    logic [63:0] tgt_high;
    logic [63:0] tgt_low;
    logic [3:0]  hop_count;
    logic [7:0]  life;
    logic [31:0] updated;
  } meta_t;

  localparam int unsigned META_W = $bits(meta_t);

  function automatic logic [SCNT_W-1:0] popcount(input logic [SLOTS-1:0] v);
    logic [SCNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < SLOTS; i++) n = n + SCNT_W'(v[i]);
    return n;
  endfunction

endpackage

[rtl/core/srte_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module srte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

[rtl/core/source_route_table_engine.sv]
// Top level of the source route table engine: control sequencer and route memories.
// Routes live in three RAMs (target and metadata per slot, path hops per slot and hop,
// and the hop staging area); valid marks are flops cleared at reset. An add hop that is
// not last only stages its hop. Remove, lookup and add-last walk the slots through the
// metadata RAM read port, one slot per cycle; an add commit then copies the staged hops
// into the path RAM, expire walks the slots in a check pass and, unless a lifetime
// product is invalid, a drop pass, and a lookup that hits reads and emits its hops one
// by one, held by any stall on the result side. The next item is taken once the previous
// one has handed its last result to the output register.
module source_route_table_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [30:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_cmd,
  input  logic [63:0]           in_target_high,
  input  logic [63:0]           in_target_low,
  input  logic [63:0]           in_hop_high,
  input  logic [63:0]           in_hop_low,
  input  logic                  in_hop_last,
  input  logic [7:0]            in_lifetime,
  input  logic [31:0]           in_now_time,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic                  out_found,
  output logic [3:0]            out_path_length,
  output logic [2:0]            out_hop_index,
  output logic [63:0]           out_hop_high,
  output logic [63:0]           out_hop_low,
  output logic [7:0]            out_route_lifetime,
  output logic [31:0]           out_route_updated,
  output logic [4:0]            out_expired_count,
  output logic [4:0]            out_route_count,
  output logic                  out_last
);
  import srte_pkg::*;

  state_t              state_r, state_nxt;
  logic [SCNT_W-1:0]   cnt_r, cnt_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [127:0]        tgt_r, tgt_nxt;
  logic [7:0]          life_r, life_nxt;
  logic [31:0]         now_r, now_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [SLOTS-1:0]    valid_r, valid_nxt;
  logic [HCNT_W-1:0]   stg_cnt_r, stg_cnt_nxt;
  logic                stg_ovf_r, stg_ovf_nxt;
  logic [SCNT_W-1:0]   exp_cnt_r, exp_cnt_nxt;
  logic                bad_r, bad_nxt;
  status_t             status_r, status_nxt;
  logic [HCNT_W-1:0]   hop_k_r, hop_k_nxt;
  logic [3:0]          plen_r, plen_nxt;
  logic [7:0]          rlife_r, rlife_nxt;
  logic [31:0]         rupd_r, rupd_nxt;
  logic [TPU_W-1:0]    tpu_r;

  logic                out_valid_r;
  logic [1:0]          o_status_r;
  logic                o_found_r;
  logic [3:0]          o_plen_r;
  logic [2:0]          o_idx_r;
  logic [127:0]        o_hop_r;
  logic [7:0]          o_life_r;
  logic [31:0]         o_upd_r;
  logic [4:0]          o_exp_r;
  logic [4:0]          o_cnt_r;
  logic                o_last_r;
  logic                load_simple, load_hop;

  // RAM ports
  logic                meta_we, meta_re;
  logic [SLOT_W-1:0]   meta_waddr, meta_raddr;
  meta_t               meta_wdata, meta_rdata;
  logic                path_we, path_re;
  logic [SLOT_W+HOP_W-1:0] path_waddr, path_raddr;
  logic [127:0]        path_rdata, stg_rdata;
  logic                stg_we, stg_re;
  logic [HOP_W-1:0]    stg_waddr, stg_raddr;

  logic                in_fire, out_free, hit, have_free;
  logic [SLOT_W-1:0]   idx, free_idx, tgt_slot;
  logic [AGE_W-1:0]    age;
  logic [31:0]         diff;
  logic                finite;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  srte_ram #(.WIDTH(META_W), .DEPTH(SLOTS)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .re(meta_re), .raddr(meta_raddr), .rdata(meta_rdata)
  );
  srte_ram #(.WIDTH(128), .DEPTH(SLOTS * HOPS)) u_path (
    .clk(clk), .we(path_we), .waddr(path_waddr), .wdata(stg_rdata),
    .re(path_re), .raddr(path_raddr), .rdata(path_rdata)
  );
  srte_ram #(.WIDTH(128), .DEPTH(HOPS)) u_stage (
    .clk(clk), .we(stg_we), .waddr(stg_waddr), .wdata({in_hop_high, in_hop_low}),
    .re(stg_re), .raddr(stg_raddr), .rdata(stg_rdata)
  );

  // entry under compare is the one read in the previous cycle
  assign idx    = SLOT_W'(cnt_r - SCNT_W'(1));
  assign hit    = (cnt_r != '0) && valid_r[idx] &&
                  ({meta_rdata.tgt_high, meta_rdata.tgt_low} == tgt_r);
  assign finite = valid_r[idx] && (meta_rdata.life != LIFE_INF);
  assign age    = AGE_W'(meta_rdata.life) * AGE_W'(tpu_r);
  assign diff   = now_r - (meta_rdata.updated + age[31:0]);

  always_comb begin
    have_free = 1'b0;
    free_idx  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        have_free = 1'b1;
        free_idx  = SLOT_W'(i);
      end
    end
  end

  assign tgt_slot = hit ? idx : free_idx;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          priority if (cmd_t'(in_cmd) == CMD_EXPIRE) state_nxt = S_EXP1;
          else if (cmd_t'(in_cmd) != CMD_ADD) state_nxt = S_SCAN;
          else if (!in_hop_last || stg_cnt_r >= HCNT_W'(HOPS) || stg_ovf_r) state_nxt = S_POST;
          else state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit || cnt_r == SCNT_W'(SLOTS)) begin
          unique case (cmd_r)
            CMD_LOOKUP: state_nxt = hit ? S_LRD : S_POST;
            CMD_ADD:    state_nxt = (hit || have_free) ? S_COPY : S_POST;
            default:    state_nxt = S_POST;
          endcase
        end
      end
      S_EXP1: if (cnt_r == SCNT_W'(SLOTS)) state_nxt = (bad_r || (finite &&
                  (age == '0 || age[AGE_W-1:31] != '0))) ? S_POST : S_EXP2;
      S_EXP2: if (cnt_r == SCNT_W'(SLOTS)) state_nxt = S_POST;
      S_COPY: if (hop_k_r == stg_cnt_r) state_nxt = S_POST;
      S_LRD:  state_nxt = S_LOUT;
      S_LOUT: if (out_free) state_nxt = (hop_k_r + HCNT_W'(1) == HCNT_W'(plen_r)) ? S_IDLE : S_LRD;
      S_POST: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_nxt     = cnt_r;
    cmd_nxt     = cmd_r;
    tgt_nxt     = tgt_r;
    life_nxt    = life_r;
    now_nxt     = now_r;
    slot_nxt    = slot_r;
    valid_nxt   = valid_r;
    stg_cnt_nxt = stg_cnt_r;
    stg_ovf_nxt = stg_ovf_r;
    exp_cnt_nxt = exp_cnt_r;
    bad_nxt     = bad_r;
    status_nxt  = status_r;
    hop_k_nxt   = hop_k_r;
    plen_nxt    = plen_r;
    rlife_nxt   = rlife_r;
    rupd_nxt    = rupd_r;
    meta_we     = 1'b0;
    meta_waddr  = tgt_slot;
    meta_wdata  = '{tgt_high: tgt_r[127:64], tgt_low: tgt_r[63:0],
                    hop_count: 4'(stg_cnt_r), life: life_r, updated: now_r};
    meta_re     = 1'b0;
    meta_raddr  = cnt_r[SLOT_W-1:0];
    path_we     = 1'b0;
    path_waddr  = {slot_r, HOP_W'(hop_k_r - HCNT_W'(1))};
    path_re     = 1'b0;
    path_raddr  = {slot_r, hop_k_r[HOP_W-1:0]};
    stg_we      = 1'b0;
    stg_waddr   = stg_cnt_r[HOP_W-1:0];
    stg_re      = 1'b0;
    stg_raddr   = hop_k_r[HOP_W-1:0];
    load_simple = 1'b0;
    load_hop    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt     = cmd_t'(in_cmd);
          tgt_nxt     = {in_target_high, in_target_low};
          life_nxt    = in_lifetime;
          now_nxt     = in_now_time;
          cnt_nxt     = '0;
          exp_cnt_nxt = '0;
          bad_nxt     = 1'b0;
          hop_k_nxt   = '0;
          status_nxt  = ST_OK;
          if (cmd_t'(in_cmd) == CMD_ADD) begin
            if (stg_cnt_r < HCNT_W'(HOPS)) begin
              stg_we      = 1'b1;
              stg_cnt_nxt = stg_cnt_r + HCNT_W'(1);
            end else begin
              stg_ovf_nxt = 1'b1;
            end
            if (in_hop_last && (stg_cnt_r >= HCNT_W'(HOPS) || stg_ovf_r)) begin
              status_nxt  = ST_INVALID;
              stg_cnt_nxt = '0;
              stg_ovf_nxt = 1'b0;
            end
          end
        end
      end
      S_SCAN: begin
        meta_re = (cnt_r < SCNT_W'(SLOTS));
        cnt_nxt = cnt_r + SCNT_W'(1);
        if (hit || cnt_r == SCNT_W'(SLOTS)) begin
          unique case (cmd_r)
            CMD_REMOVE: begin
              if (hit) valid_nxt[idx] = 1'b0;
              else status_nxt = ST_NOTFOUND;
            end
            CMD_LOOKUP: begin
              slot_nxt  = idx;
              plen_nxt  = meta_rdata.hop_count;
              rlife_nxt = meta_rdata.life;
              rupd_nxt  = meta_rdata.updated;
              if (!hit) status_nxt = ST_NOTFOUND;
            end
            default: begin
              slot_nxt = tgt_slot;
              if (hit || have_free) begin
                meta_we             = 1'b1;
                valid_nxt[tgt_slot] = 1'b1;
              end else begin
                status_nxt  = ST_FULL;
                stg_cnt_nxt = '0;
                stg_ovf_nxt = 1'b0;
              end
            end
          endcase
        end
      end
      S_EXP1: begin
        meta_re = (cnt_r < SCNT_W'(SLOTS));
        cnt_nxt = cnt_r + SCNT_W'(1);
        if (cnt_r != '0 && finite && (age == '0 || age[AGE_W-1:31] != '0)) bad_nxt = 1'b1;
        if (cnt_r == SCNT_W'(SLOTS)) begin
          cnt_nxt = '0;
          if (bad_nxt) status_nxt = ST_INVALID;
        end
      end
      S_EXP2: begin
        meta_re = (cnt_r < SCNT_W'(SLOTS));
        cnt_nxt = cnt_r + SCNT_W'(1);
        // drop when the deadline is not in the future
        if (cnt_r != '0 && finite && !diff[31]) begin
          valid_nxt[idx] = 1'b0;
          exp_cnt_nxt    = exp_cnt_r + SCNT_W'(1);
        end
      end
      S_COPY: begin
        stg_re    = (hop_k_r < stg_cnt_r);
        path_we   = (hop_k_r != '0);
        hop_k_nxt = hop_k_r + HCNT_W'(1);
        if (hop_k_r == stg_cnt_r) begin
          stg_cnt_nxt = '0;
          stg_ovf_nxt = 1'b0;
        end
      end
      S_LRD: path_re = 1'b1;
      S_LOUT: begin
        if (out_free) begin
          load_hop  = 1'b1;
          hop_k_nxt = hop_k_r + HCNT_W'(1);
        end
      end
      S_POST: load_simple = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      stg_cnt_r   <= '0;
      stg_ovf_r   <= 1'b0;
      tpu_r       <= TPU_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      stg_cnt_r <= stg_cnt_nxt;
      stg_ovf_r <= stg_ovf_nxt;
      if (cfg_valid && cfg_ready) tpu_r <= cfg_data;
      if (load_simple || load_hop) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    cmd_r     <= cmd_nxt;
    tgt_r     <= tgt_nxt;
    life_r    <= life_nxt;
    now_r     <= now_nxt;
    slot_r    <= slot_nxt;
    exp_cnt_r <= exp_cnt_nxt;
    bad_r     <= bad_nxt;
    status_r  <= status_nxt;
    hop_k_r   <= hop_k_nxt;
    plen_r    <= plen_nxt;
    rlife_r   <= rlife_nxt;
    rupd_r    <= rupd_nxt;
    if (load_simple) begin
      o_status_r <= status_r;
      o_found_r  <= 1'b0;
      o_plen_r   <= '0;
      o_idx_r    <= '0;
      o_hop_r    <= '0;
      o_life_r   <= '0;
      o_upd_r    <= '0;
      o_exp_r    <= 5'(exp_cnt_r);
      o_cnt_r    <= 5'(popcount(valid_r));
      o_last_r   <= 1'b1;
    end else if (load_hop) begin
      o_status_r <= ST_OK;
      o_found_r  <= 1'b1;
      o_plen_r   <= plen_r;
      o_idx_r    <= 3'(hop_k_r);
      o_hop_r    <= path_rdata;
      o_life_r   <= rlife_r;
      o_upd_r    <= rupd_r;
      o_exp_r    <= '0;
      o_cnt_r    <= 5'(popcount(valid_r));
      o_last_r   <= (hop_k_r + HCNT_W'(1) == HCNT_W'(plen_r));
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = o_status_r;
  assign out_found          = o_found_r;
  assign out_path_length    = o_plen_r;
  assign out_hop_index      = o_idx_r;
  assign out_hop_high       = o_hop_r[127:64];
  assign out_hop_low        = o_hop_r[63:0];
  assign out_route_lifetime = o_life_r;
  assign out_route_updated  = o_upd_r;
  assign out_expired_count  = o_exp_r;
  assign out_route_count    = o_cnt_r;
  assign out_last           = o_last_r;

  a_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stg_cnt_r <= HCNT_W'(HOPS))
    else $error("staged hop count beyond path limit");

  a_copy_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY) |-> valid_r[slot_r])
    else $error("hop copy into a slot that is not valid");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("item accepted while previous item still at work");

endmodule

[tb/tb_source_route_table_engine.sv]
// Testbench for the source route table engine: scoreboard class, stimulus and checks.
module tb_source_route_table_engine;
  import srte_pkg::*;

  typedef struct {
    logic [1:0]  status;
    logic        found;
    logic [3:0]  path_length;
    logic [2:0]  hop_index;
    logic [63:0] hop_high;
    logic [63:0] hop_low;
    logic [7:0]  route_lifetime;
    logic [31:0] route_updated;
    logic [4:0]  expired_count;
    logic [4:0]  route_count;
    logic        last;
  } route_result_t;

  class route_table_board;
    logic [30:0]  ticks_per_unit;
    bit           valid_mark [SLOTS];
    logic [63:0]  tgt_hi [SLOTS];
    logic [63:0]  tgt_lo [SLOTS];
    logic [63:0]  path_hi [SLOTS][HOPS];
    logic [63:0]  path_lo [SLOTS][HOPS];
    int unsigned  route_hops [SLOTS];
    logic [7:0]   life [SLOTS];
    logic [31:0]  updated [SLOTS];
    logic [63:0]  stage_hi [HOPS];
    logic [63:0]  stage_lo [HOPS];
    int unsigned  stage_count;
    bit           stage_overflow;
    route_result_t pending[$];
    int           errors;

    function new();
      ticks_per_unit = TPU_RESET;
      stage_count = 0;
      stage_overflow = 0;
      errors = 0;
      foreach (valid_mark[i]) valid_mark[i] = 0;
    endfunction

    function int match_slot(logic [63:0] hi, logic [63:0] lo);
      for (int i = 0; i < SLOTS; i++)
        if (valid_mark[i] && tgt_hi[i] == hi && tgt_lo[i] == lo) return i;
      return -1;
    endfunction

    function route_result_t plain(status_t st, int unsigned dropped);
      route_result_t r;
      int unsigned n;
      n = 0;
      foreach (valid_mark[i]) n += valid_mark[i];
      r = '{default: '0};
      r.status = st;
      r.expired_count = dropped[4:0];
      r.route_count = n[4:0];
      r.last = 1'b1;
      return r;
    endfunction

    function status_t add_hop(logic [63:0] th, logic [63:0] tl, logic [63:0] hh,
                              logic [63:0] hl, logic hop_last, logic [7:0] lt,
                              logic [31:0] now);
      int slot;
      status_t st;
      st = ST_OK;
      if (stage_count < HOPS) begin
        stage_hi[stage_count] = hh;
        stage_lo[stage_count] = hl;
        stage_count++;
      end else stage_overflow = 1;
      if (!hop_last) return ST_OK;
      if (stage_overflow) st = ST_INVALID;
      else begin
        slot = match_slot(th, tl);
        if (slot < 0)
          for (int i = 0; i < SLOTS; i++)
            if (!valid_mark[i]) begin
              slot = i;
              break;
            end
        if (slot < 0) st = ST_FULL;
        else begin
          tgt_hi[slot] = th;
          tgt_lo[slot] = tl;
          for (int k = 0; k < stage_count; k++) begin
            path_hi[slot][k] = stage_hi[k];
            path_lo[slot][k] = stage_lo[k];
          end
          route_hops[slot] = stage_count;
          life[slot] = lt;
          updated[slot] = now;
          valid_mark[slot] = 1;
        end
      end
      stage_count = 0;
      stage_overflow = 0;
      return st;
    endfunction

    function void expire_sweep(logic [31:0] now);
      logic [39:0] age;
      logic [31:0] deadline, diff;
      int unsigned dropped;
      dropped = 0;
      for (int i = 0; i < SLOTS; i++)
        if (valid_mark[i] && life[i] != LIFE_INF) begin
          age = 40'(life[i]) * 40'(ticks_per_unit);
          if (age == 0 || age > 40'h7FFF_FFFF) begin
            pending.push_back(plain(ST_INVALID, 0));
            return;
          end
        end
      for (int i = 0; i < SLOTS; i++)
        if (valid_mark[i] && life[i] != LIFE_INF) begin
          age = 40'(life[i]) * 40'(ticks_per_unit);
          deadline = updated[i] + age[31:0];
          diff = now - deadline;
          if (!diff[31]) begin
            valid_mark[i] = 0;
            dropped++;
          end
        end
      pending.push_back(plain(ST_OK, dropped));
    endfunction

    // note an accepted input item and queue the results it causes
    function void note_item(cmd_t cmd, logic [63:0] th, logic [63:0] tl, logic [63:0] hh,
                            logic [63:0] hl, logic hop_last, logic [7:0] lt,
                            logic [31:0] now);
      int slot;
      route_result_t r;
      status_t st;
      case (cmd)
        CMD_ADD: begin
          st = add_hop(th, tl, hh, hl, hop_last, lt, now);
          pending.push_back(plain(st, 0));
        end
        CMD_REMOVE: begin
          slot = match_slot(th, tl);
          if (slot >= 0) valid_mark[slot] = 0;
          pending.push_back(plain(slot < 0 ? ST_NOTFOUND : ST_OK, 0));
        end
        CMD_LOOKUP: begin
          slot = match_slot(th, tl);
          if (slot < 0) pending.push_back(plain(ST_NOTFOUND, 0));
          else
            for (int k = 0; k < route_hops[slot]; k++) begin
              r = plain(ST_OK, 0);
              r.found = 1;
              r.path_length = route_hops[slot][3:0];
              r.hop_index = k[2:0];
              r.hop_high = path_hi[slot][k];
              r.hop_low = path_lo[slot][k];
              r.route_lifetime = life[slot];
              r.route_updated = updated[slot];
              r.last = (k + 1 == route_hops[slot]);
              pending.push_back(r);
            end
        end
        default: expire_sweep(now);
      endcase
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(route_result_t got);
      route_result_t w;
      if (pending.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      w = pending.pop_front();
      if (got.status !== w.status) report("status", got.status, w.status);
      if (got.found !== w.found) report("found", got.found, w.found);
      if (got.path_length !== w.path_length)
        report("path_length", got.path_length, w.path_length);
      if (got.hop_index !== w.hop_index) report("hop_index", got.hop_index, w.hop_index);
      if (got.hop_high !== w.hop_high) report("hop_high", got.hop_high, w.hop_high);
      if (got.hop_low !== w.hop_low) report("hop_low", got.hop_low, w.hop_low);
      if (got.route_lifetime !== w.route_lifetime)
        report("route_lifetime", got.route_lifetime, w.route_lifetime);
      if (got.route_updated !== w.route_updated)
        report("route_updated", got.route_updated, w.route_updated);
      if (got.expired_count !== w.expired_count)
        report("expired_count", got.expired_count, w.expired_count);
      if (got.route_count !== w.route_count)
        report("route_count", got.route_count, w.route_count);
      if (got.last !== w.last) report("last", got.last, w.last);
    endtask
  endclass

  localparam int STALL_LIMIT = 20000;

  logic        clk, rst_n;
  logic        cfg_valid, cfg_ready;
  logic [30:0] cfg_data;
  logic        in_valid, in_ready;
  logic [1:0]  in_cmd;
  logic [63:0] in_target_high, in_target_low, in_hop_high, in_hop_low;
  logic        in_hop_last;
  logic [7:0]  in_lifetime;
  logic [31:0] in_now_time;
  logic        out_valid, out_ready;
  logic [1:0]  out_status;
  logic        out_found;
  logic [3:0]  out_path_length;
  logic [2:0]  out_hop_index;
  logic [63:0] out_hop_high, out_hop_low;
  logic [7:0]  out_route_lifetime;
  logic [31:0] out_route_updated;
  logic [4:0]  out_expired_count, out_route_count;
  logic        out_last;

  route_table_board board;
  logic [63:0] known_hi [8];
  logic [63:0] known_lo [8];
  logic [31:0] clock_now;
  bit          hold_off;
  bit          sending_done;
  int          quiet_cycles;

  source_route_table_engine DUT (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task send_item(cmd_t cmd, logic [63:0] th, logic [63:0] tl, logic [63:0] hh,
                 logic [63:0] hl, logic hl_last, logic [7:0] lt, logic [31:0] now);
    int unsigned g;
    in_valid <= 1;
    in_cmd <= cmd;
    in_target_high <= th;
    in_target_low <= tl;
    in_hop_high <= hh;
    in_hop_low <= hl;
    in_hop_last <= hl_last;
    in_lifetime <= lt;
    in_now_time <= now;
    do @(posedge clk); while (!in_ready);
    board.note_item(cmd, th, tl, hh, hl, hl_last, lt, now);
    if ($urandom_range(0, 3) == 0) begin
      g = gap_len();
      if (g != 0) begin
        in_valid <= 0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  task write_ticks(logic [30:0] v);
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    // an add hop that is not last yields its result as the block returns to idle
    repeat (40) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    board.ticks_per_unit = v;
  endtask

  task add_route(logic [63:0] th, logic [63:0] tl, int unsigned hops, logic [7:0] lt,
                 logic [31:0] now);
    for (int k = 0; k < hops; k++)
      send_item(CMD_ADD, th, tl, {$urandom, $urandom}, {$urandom, $urandom},
                k == hops - 1, lt, now);
  endtask

  function logic [7:0] pick_life();
    int unsigned p;
    p = $urandom_range(0, 9);
    if (p < 2) return LIFE_INF;
    if (p < 3) return 8'($urandom);
    return 8'($urandom_range(1, 20));
  endfunction

  task random_item();
    int unsigned p, k;
    p = $urandom_range(0, 99);
    k = $urandom_range(0, 7);
    clock_now += $urandom_range(0, 6);
    if (p < 40) add_route(known_hi[k], known_lo[k],
                          $urandom_range(0, 9) == 0 ? 9 : $urandom_range(1, 4),
                          pick_life(), clock_now);
    else if (p < 65) send_item(CMD_LOOKUP, known_hi[k], known_lo[k], 0, 0, 0, 0, 0);
    else if (p < 77) send_item(CMD_REMOVE, known_hi[k], known_lo[k], 0, 0, 0, 0, 0);
    else if (p < 87) send_item(CMD_EXPIRE, 0, 0, 0, 0, 0, 0, clock_now);
    else
      // noise: random fields, fresh targets, stray hops
      send_item(cmd_t'($urandom_range(0, 3)), {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                8'($urandom), $urandom);
  endtask

  // result side: random stalls plus one long hold-off
  initial begin
    route_result_t r;
    int unsigned g;
    out_ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      out_ready <= ($urandom_range(0, 4) != 0);
      @(posedge clk);
      if (out_valid && out_ready) begin
        r.status = out_status;
        r.found = out_found;
        r.path_length = out_path_length;
        r.hop_index = out_hop_index;
        r.hop_high = out_hop_high;
        r.hop_low = out_hop_low;
        r.route_lifetime = out_route_lifetime;
        r.route_updated = out_route_updated;
        r.expired_count = out_expired_count;
        r.route_count = out_route_count;
        r.last = out_last;
        board.check_result(r);
      end
      if ($urandom_range(0, 29) == 0) begin
        g = gap_len();
        if (g != 0) begin
          out_ready <= 0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  // watchdog: cycles with no handshake on any channel
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    board = new();
    sending_done = 0;
    hold_off = 0;
    clock_now = $urandom;
    rst_n = 0;
    cfg_valid = 0;
    cfg_data = 0;
    in_valid = 0;
    in_cmd = CMD_ADD;
    in_target_high = 0;
    in_target_low = 0;
    in_hop_high = 0;
    in_hop_low = 0;
    in_hop_last = 0;
    in_lifetime = 0;
    in_now_time = 0;
    for (int i = 0; i < 8; i++) begin
      known_hi[i] = {$urandom, $urandom};
      known_lo[i] = {$urandom, $urandom};
    end
    known_hi[0] = '1;
    known_lo[0] = '1;
    known_hi[1] = '0;
    known_lo[1] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, every command, each special case
    send_item(CMD_LOOKUP, '1, '1, 0, 0, 0, 0, 0);
    send_item(CMD_REMOVE, '1, '1, 0, 0, 0, 0, 0);
    send_item(CMD_EXPIRE, 0, 0, 0, 0, 0, 0, '1);
    send_item(CMD_ADD, '1, '1, '1, '1, 1, LIFE_INF, '1);
    add_route('0, '0, HOPS, 8'd0, 32'd0);
    send_item(CMD_LOOKUP, '0, '0, 0, 0, 0, 0, 0);
    // zero lifetime product blocks the sweep
    send_item(CMD_EXPIRE, 0, 0, 0, 0, 0, 0, 32'd100);
    add_route('0, '0, HOPS + 1, 8'd3, 32'hFFFF_FFFE);
    add_route('0, '0, 2, 8'd3, 32'hFFFF_FFFE);
    send_item(CMD_ADD, '1, '1, 0, 0, 0, 0, 0);
    send_item(CMD_LOOKUP, '1, '1, 0, 0, 0, 0, 0);
    send_item(CMD_ADD, '1, '1, 64'h5, 64'h6, 1, 8'd200, 32'h8000_0000);
    send_item(CMD_EXPIRE, 0, 0, 0, 0, 0, 0, 32'd0);
    send_item(CMD_EXPIRE, 0, 0, 0, 0, 0, 0, 32'd2);
    send_item(CMD_REMOVE, '1, '1, 0, 0, 0, 0, 0);
    // fill the table, then one more target
    for (int i = 0; i < SLOTS; i++) add_route(64'(i), 64'(i + 100), 1, LIFE_INF, 0);
    send_item(CMD_ADD, 64'h77, 64'h77, 0, 0, 1, 8'd1, 0);

    write_ticks('1);
    send_item(CMD_EXPIRE, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < SLOTS; i++) send_item(CMD_REMOVE, 64'(i), 64'(i + 100), 0, 0, 0, 0, 0);
    write_ticks(31'd0);
    write_ticks(31'd1);

    for (int n = 0; n < 195; n++) begin
      if (n == 75) hold_off = 1;
      if (n == 65) write_ticks(31'd1000);
      if (n == 130) write_ticks(31'h0100_0000);
      if (n == 165) write_ticks(31'd3);
      random_item();
    end
    in_valid <= 0;
    sending_done = 1;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
